// ----- rtl/core/fhcg_pkg.sv -----
// shared types, codes and constants for the force-hold caret gesture block
`default_nettype none
package fhcg_pkg;

  // configuration defaults and widths
  localparam int MAX_STEPS_DEF   = 4;
  localparam int ACCUM_WIDTH_DEF = 24;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [15:0] HOLD_TIME_RST = 16'd300;
  localparam logic [11:0] DEADZONE_RST  = 12'd50;
  localparam logic [11:0] MOVE_THR_RST  = 12'd10;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HOLD_TIME = 2'd0,
    REG_DEADZONE  = 2'd1,
    REG_MOVE_THR  = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ACT_PRESS    = 3'd0,
    ACT_RELEASE  = 3'd1,
    ACT_MOTION_X = 3'd2,
    ACT_MOTION_Y = 3'd3,
    ACT_TICK     = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    K_FORWARD      = 4'd0,
    K_CONSUMED     = 4'd1,
    K_PRIMARY_REL  = 4'd2,
    K_ENTRY_HAPTIC = 4'd3,
    K_LEFT         = 4'd4,
    K_RIGHT        = 4'd5,
    K_UP           = 4'd6,
    K_DOWN         = 4'd7,
    K_STEP_HAPTIC  = 4'd8,
    K_NOTHING      = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CAND  = 2'd1,
    MODE_CARET = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_STEP,
    ST_DIR,
    ST_HAP,
    ST_FIRST,
    ST_FINAL
  } fhcg_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic decide;
    logic step_eval;
    logic emit_first;
    logic emit_dir;
    logic emit_hap;
    logic emit_final;
  } fhcg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic caret_motion;
    logic two_results;
    logic step_go;
    logic slot_free;
  } fhcg_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/force_hold_caret_gesture.sv -----
// force-hold caret gesture classifier, top level
//
// input channel (in_valid/in_ready): one trackpad event per transfer, with
// action, source_side and motion_value. output channel (out_valid/out_ready):
// one result per transfer, kind and target_side, last marks the final result
// of an event. config channel (cfg_valid/cfg_ready, always ready): cfg_index
// selects hold time, step deadzone or move threshold, cfg_data is the value.
//
// events are handled one at a time by a sequencer over a shared datapath.
// a plain event goes through decide and the final emit before the next
// transfer in, a hold-time tick that enters caret mode emits a first result
// ahead of the final one, and a caret motion runs the step loop for n
// direction steps (n up to MAX_STEPS): an evaluation, then a direction result
// and a step haptic per step. the first result is registered from the emit
// state that follows decide, or the step evaluation for a caret motion.
// a registered output stage lets a new event be taken while the last result
// still waits; a stalled receiver holds the sequencer in its emit state.
// reset (synchronous, rst high) returns to idle with all sums cleared and
// the config registers at 300 / 50 / 10.
`default_nettype none
module force_hold_caret_gesture #(
  parameter int MAX_STEPS   = fhcg_pkg::MAX_STEPS_DEF,
  parameter int ACCUM_WIDTH = fhcg_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // config writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fhcg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fhcg_pkg::CFG_DATA_W-1:0]  cfg_data,
  // event input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       action,
  input  logic [1:0]                       source_side,
  input  logic signed [15:0]               motion_value,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       kind,
  output logic [1:0]                       target_side,
  output logic                             last
);
  import fhcg_pkg::*;

  fhcg_cmd_t  cmd;
  fhcg_stat_t stat;

  // sequencer: decide, step loop, emit
  fhcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state, step arithmetic and output register
  fhcg_dp #(
    .MAX_STEPS   (MAX_STEPS),
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .source_side  (source_side),
    .motion_value (motion_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .target_side  (target_side),
    .last         (last),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
`default_nettype wire

// ----- rtl/core/fhcg_ctrl.sv -----
// sequencing state machine of the force-hold caret gesture block
`default_nettype none
module fhcg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fhcg_pkg::fhcg_stat_t stat,
  output fhcg_pkg::fhcg_cmd_t  cmd
);
  import fhcg_pkg::*;

  fhcg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.caret_motion)     state_next = ST_STEP;
        else if (stat.two_results) state_next = ST_FIRST;
        else                       state_next = ST_FINAL;
      end
      ST_STEP: begin
        state_next = stat.step_go ? ST_DIR : ST_FINAL;
      end
      ST_DIR: begin
        if (stat.slot_free) state_next = ST_HAP;
      end
      ST_HAP: begin
        if (stat.slot_free) state_next = ST_STEP;
      end
      ST_FIRST: begin
        if (stat.slot_free) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (stat.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_DECIDE: cmd.decide     = 1'b1;
      ST_STEP:   cmd.step_eval  = 1'b1;
      ST_DIR:    cmd.emit_dir   = stat.slot_free;
      ST_HAP:    cmd.emit_hap   = stat.slot_free;
      ST_FIRST:  cmd.emit_first = stat.slot_free;
      ST_FINAL:  cmd.emit_final = stat.slot_free;
      default: ;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_latch_then_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> cmd.decide)
    else $error("accepted item not decided in next cycle");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_final |=> in_ready)
    else $error("not ready after the final result");

endmodule
`default_nettype wire

// ----- rtl/core/fhcg_dp.sv -----
// datapath: config registers, gesture state, step engine and output register
`default_nettype none
module fhcg_dp #(
  parameter int MAX_STEPS   = fhcg_pkg::MAX_STEPS_DEF,
  parameter int ACCUM_WIDTH = fhcg_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fhcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fhcg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [2:0]                         action,
  input  logic [1:0]                         source_side,
  input  logic [15:0]                        motion_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [3:0]                         kind,
  output logic [1:0]                         target_side,
  output logic                               last,
  input  fhcg_pkg::fhcg_cmd_t                cmd,
  output fhcg_pkg::fhcg_stat_t               stat
);
  import fhcg_pkg::*;

  localparam int AW = ACCUM_WIDTH;
  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam logic [SW-1:0] STEP_LIMIT = SW'(MAX_STEPS);
  localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  // configuration
  logic [15:0] hold_time;
  logic [11:0] step_deadzone;
  logic [11:0] move_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time      <= HOLD_TIME_RST;
      step_deadzone  <= DEADZONE_RST;
      move_threshold <= MOVE_THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOLD_TIME: hold_time      <= cfg_data;
        REG_DEADZONE:  step_deadzone  <= cfg_data[11:0];
        REG_MOVE_THR:  move_threshold <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [2:0]  item_action;
  logic [1:0]  item_side;
  logic [15:0] item_value;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_action <= action;
      item_side   <= source_side;
      item_value  <= motion_value;
    end
  end

  // gesture state
  mode_t         mode, mode_next;
  logic [1:0]    session_side, session_side_next;
  logic [15:0]   hold_count, hold_count_next;
  logic [AW-1:0] accum_x, accum_x_next;
  logic [AW-1:0] accum_y, accum_y_next;
  logic [SW-1:0] steps;

  // final result of the item, set at decide
  kind_t      fin_kind;
  logic [1:0] fin_side;

  // step engine
  kind_t dir_kind;
  logic  dir_x;
  logic  dir_neg;

  logic [AW-1:0] dz;
  assign dz = {{(AW-12){1'b0}}, step_deadzone};

  // decide helpers
  logic          value_zero;
  logic [16:0]   value_mag;
  logic [15:0]   hold_inc;
  logic          hold_reached;
  logic [AW-1:0] acc_sel;
  logic [AW:0]   acc_sum;
  logic [AW-1:0] acc_sat;

  assign value_zero   = (item_value == 16'd0);
  assign value_mag    = item_value[15] ? (17'd0 - {1'b1, item_value}) : {1'b0, item_value};
  assign hold_inc     = (hold_count == 16'hFFFF) ? hold_count : hold_count + 16'd1;
  assign hold_reached = (hold_inc >= hold_time);
  assign acc_sel      = (item_action == ACT_MOTION_X) ? accum_x : accum_y;
  assign acc_sum      = {acc_sel[AW-1], acc_sel}
                      + {{(AW+1-16){item_value[15]}}, item_value};
  assign acc_sat      = (acc_sum[AW] != acc_sum[AW-1]) ? (acc_sum[AW] ? ACC_MIN : ACC_MAX)
                                                       : acc_sum[AW-1:0];

  mode_t         dec_mode;
  logic [1:0]    dec_session;
  logic [15:0]   dec_hold;
  logic [AW-1:0] dec_ax;
  logic [AW-1:0] dec_ay;
  kind_t         dec_kind;
  logic [1:0]    dec_side;
  logic          dec_two;
  logic          dec_caret;

  always_comb begin
    dec_mode    = mode;
    dec_session = session_side;
    dec_hold    = hold_count;
    dec_ax      = accum_x;
    dec_ay      = accum_y;
    dec_kind    = K_FORWARD;
    dec_side    = item_side;
    dec_two     = 1'b0;
    dec_caret   = 1'b0;
    unique case (item_action)
      ACT_PRESS: begin
        if (mode == MODE_IDLE) begin
          dec_mode    = MODE_CAND;
          dec_session = item_side;
          dec_hold    = '0;
          dec_ax      = '0;
          dec_ay      = '0;
        end
      end
      ACT_RELEASE: begin
        if (mode != MODE_IDLE && session_side == item_side) begin
          if (mode == MODE_CARET) dec_kind = K_CONSUMED;
          dec_mode    = MODE_IDLE;
          dec_session = '0;
          dec_hold    = '0;
          dec_ax      = '0;
          dec_ay      = '0;
        end
      end
      ACT_MOTION_X, ACT_MOTION_Y: begin
        if (!value_zero && mode == MODE_CAND) begin
          if (value_mag >= {5'd0, move_threshold}) begin
            dec_mode    = MODE_IDLE;
            dec_session = '0;
            dec_hold    = '0;
            dec_ax      = '0;
            dec_ay      = '0;
          end
        end else if (!value_zero && mode == MODE_CARET) begin
          dec_caret = 1'b1;
          dec_kind  = K_CONSUMED;
          if (item_action == ACT_MOTION_X) dec_ax = acc_sat;
          else                             dec_ay = acc_sat;
        end
      end
      ACT_TICK: begin
        dec_kind = K_NOTHING;
        dec_side = '0;
        if (mode == MODE_CAND) begin
          dec_hold = hold_inc;
          if (hold_reached) begin
            dec_mode = MODE_CARET;
            dec_ax   = '0;
            dec_ay   = '0;
            dec_two  = 1'b1;
            dec_kind = K_ENTRY_HAPTIC;
            dec_side = session_side;
          end
        end
      end
      default: ;
    endcase
  end

  // step evaluation on the dominant axis
  logic [AW-1:0] ax_mag, ay_mag, max_mag;
  logic          pick_x;
  logic          step_go;

  assign ax_mag  = accum_x[AW-1] ? (~accum_x + 1'b1) : accum_x;
  assign ay_mag  = accum_y[AW-1] ? (~accum_y + 1'b1) : accum_y;
  assign pick_x  = (ax_mag >= ay_mag);
  assign max_mag = pick_x ? ax_mag : ay_mag;
  assign step_go = (steps < STEP_LIMIT) && (max_mag >= dz);

  always_ff @(posedge clk) begin
    if (cmd.step_eval) begin
      dir_x   <= pick_x;
      dir_neg <= pick_x ? accum_x[AW-1] : accum_y[AW-1];
      if (pick_x) dir_kind <= accum_x[AW-1] ? K_LEFT : K_RIGHT;
      else        dir_kind <= accum_y[AW-1] ? K_UP : K_DOWN;
    end
    if (cmd.decide) begin
      fin_kind <= dec_kind;
      fin_side <= dec_side;
    end
  end

  // state next values
  always_comb begin
    mode_next         = mode;
    session_side_next = session_side;
    hold_count_next   = hold_count;
    accum_x_next      = accum_x;
    accum_y_next      = accum_y;
    if (cmd.decide) begin
      mode_next         = dec_mode;
      session_side_next = dec_session;
      hold_count_next   = dec_hold;
      accum_x_next      = dec_ax;
      accum_y_next      = dec_ay;
    end else if (cmd.emit_dir) begin
      // magnitude is at least dz here, so no wrap
      if (dir_x) accum_x_next = dir_neg ? accum_x + dz : accum_x - dz;
      else       accum_y_next = dir_neg ? accum_y + dz : accum_y - dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      session_side <= '0;
      hold_count   <= '0;
      accum_x      <= '0;
      accum_y      <= '0;
      steps        <= '0;
    end else begin
      mode         <= mode_next;
      session_side <= session_side_next;
      hold_count   <= hold_count_next;
      accum_x      <= accum_x_next;
      accum_y      <= accum_y_next;
      if (cmd.decide)        steps <= '0;
      else if (cmd.emit_hap) steps <= steps + 1'b1;
    end
  end

  // output register
  logic  any_emit;
  kind_t out_kind;

  assign any_emit = cmd.emit_first | cmd.emit_dir | cmd.emit_hap | cmd.emit_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (any_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_first) begin
      out_kind    <= K_PRIMARY_REL;
      target_side <= session_side;
      last        <= 1'b0;
    end else if (cmd.emit_dir) begin
      out_kind    <= dir_kind;
      target_side <= session_side;
      last        <= 1'b0;
    end else if (cmd.emit_hap) begin
      out_kind    <= K_STEP_HAPTIC;
      target_side <= item_side;
      last        <= 1'b0;
    end else if (cmd.emit_final) begin
      out_kind    <= fin_kind;
      target_side <= fin_side;
      last        <= 1'b1;
    end
  end

  assign kind = out_kind;

  assign stat.caret_motion = dec_caret;
  assign stat.two_results  = dec_two;
  assign stat.step_go      = step_go;
  assign stat.slot_free    = !out_valid || out_ready;

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    any_emit |-> (!out_valid || out_ready))
    else $error("result loaded over one not yet taken");

  a_step_bound: assert property (@(posedge clk) disable iff (rst) steps <= STEP_LIMIT)
    else $error("step count beyond limit");

  a_enter_caret: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && dec_two) |=> (mode == MODE_CARET))
    else $error("hold reached without entering caret mode");

endmodule
`default_nettype wire
